/* src/rsof_pkg.sv */
// shared types, constants and the microcode program of the rolling sigma outlier filter
`default_nettype none

package rsof_pkg;

  // item and arithmetic widths
  localparam int DATA_W     = 32;
  localparam int LIMB_W     = 32;
  localparam int ACC_LIMBS  = 4;
  localparam int ACC_W      = LIMB_W * ACC_LIMBS;
  localparam int B_LIMBS    = 2;
  localparam int B_W        = LIMB_W * B_LIMBS;
  localparam int PROD_W     = 2 * LIMB_W;
  localparam int LEN_W      = 5;
  localparam int K_W        = 16;
  localparam int K_FRAC     = 8;
  localparam int SCALE_SH   = 2 * K_FRAC;
  localparam int STEP_W     = 6;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_K = CFG_IDX_W'(1);

  // defaults
  localparam int MAX_WINDOW_DEF = 16;
  localparam int MIN_WINDOW     = 2;
  localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(5);
  localparam logic [K_W-1:0]   K_RST   = K_W'(829);

  // program labels
  localparam logic [STEP_W-1:0] ST_IDLE     = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_DISPATCH = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_LOOP     = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_FINISH   = STEP_W'(42);
  localparam logic [STEP_W-1:0] ST_WARM     = STEP_W'(43);

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_ITEM,
    COND_WARM,
    COND_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    SRC_A_NONE,
    SRC_A_ACC,
    SRC_A_SM,
    SRC_A_DEV
  } a_src_t;

  typedef enum logic [2:0] {
    SRC_B_NONE,
    SRC_B_N,
    SRC_B_K,
    SRC_B_SM,
    SRC_B_DEV,
    SRC_B_NM1S
  } b_src_t;

  typedef enum logic [1:0] {
    COMMIT_NONE,
    COMMIT_WARM,
    COMMIT_TEST
  } commit_t;

  // one control word of the program
  typedef struct packed {
    logic              take;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              ret;
    logic              init;
    logic              rd;
    a_src_t            ld_a;
    b_src_t            ld_b;
    logic              ld_r;
    logic              clr_acc;
    logic              mac;
    logic [1:0]        a_limb;
    logic              b_limb;
    logic [1:0]        sh;
    logic              sub;
    commit_t           commit;
  } ctl_t;

  // status flags from the datapath to the sequencer
  typedef struct packed {
    logic warm;
    logic more;
    logic out_busy;
  } sts_t;

  function automatic ctl_t uc_nop();
    ctl_t w;
    w = '0;
    return w;
  endfunction

  // limb product, shifted by whole limbs, added to or taken from the accumulator
  function automatic ctl_t uc_mac(logic [1:0] a_limb, logic b_limb, logic [1:0] sh,
                                  logic sub);
    ctl_t w;
    w        = uc_nop();
    w.mac    = 1'b1;
    w.a_limb = a_limb;
    w.b_limb = b_limb;
    w.sh     = sh;
    w.sub    = sub;
    return w;
  endfunction

  // operand loads, optional accumulator clear and rhs capture
  function automatic ctl_t uc_load(a_src_t a, b_src_t b, logic clr, logic ld_r);
    ctl_t w;
    w         = uc_nop();
    w.ld_a    = a;
    w.ld_b    = b;
    w.clr_acc = clr;
    w.ld_r    = ld_r;
    return w;
  endfunction

  // program rom
  function automatic ctl_t rsof_ucode(logic [STEP_W-1:0] step);
    ctl_t w;
    w = uc_nop();
    unique case (step)
      ST_IDLE: begin
        w.take   = 1'b1;
        w.cond   = COND_NO_ITEM;
        w.target = ST_IDLE;
      end
      ST_DISPATCH: begin
        w.init   = 1'b1;
        w.cond   = COND_WARM;
        w.target = ST_WARM;
      end
      ST_LOOP: begin
        w.rd     = 1'b1;
        w.cond   = COND_MORE;
        w.target = ST_LOOP;
      end
      // n times sum of squares
      STEP_W'(5):  w = uc_load(SRC_A_ACC, SRC_B_N, 1'b1, 1'b0);
      STEP_W'(6):  w = uc_mac(2'd0, 1'b0, 2'd0, 1'b0);
      STEP_W'(7):  w = uc_mac(2'd1, 1'b0, 2'd1, 1'b0);
      STEP_W'(8):  w = uc_mac(2'd2, 1'b0, 2'd2, 1'b0);
      // minus square of the sum
      STEP_W'(9):  w = uc_load(SRC_A_SM, SRC_B_SM, 1'b0, 1'b0);
      STEP_W'(10): w = uc_mac(2'd0, 1'b0, 2'd0, 1'b1);
      STEP_W'(11): w = uc_mac(2'd0, 1'b1, 2'd1, 1'b1);
      STEP_W'(12): w = uc_mac(2'd1, 1'b0, 2'd1, 1'b1);
      STEP_W'(13): w = uc_mac(2'd1, 1'b1, 2'd2, 1'b1);
      // spread times k
      STEP_W'(15): w = uc_load(SRC_A_ACC, SRC_B_K, 1'b1, 1'b0);
      STEP_W'(16): w = uc_mac(2'd0, 1'b0, 2'd0, 1'b0);
      STEP_W'(17): w = uc_mac(2'd1, 1'b0, 2'd1, 1'b0);
      STEP_W'(18): w = uc_mac(2'd2, 1'b0, 2'd2, 1'b0);
      // times k again
      STEP_W'(20): w = uc_load(SRC_A_ACC, SRC_B_K, 1'b1, 1'b0);
      STEP_W'(21): w = uc_mac(2'd0, 1'b0, 2'd0, 1'b0);
      STEP_W'(22): w = uc_mac(2'd1, 1'b0, 2'd1, 1'b0);
      STEP_W'(23): w = uc_mac(2'd2, 1'b0, 2'd2, 1'b0);
      // times n gives the right-hand side
      STEP_W'(25): w = uc_load(SRC_A_ACC, SRC_B_N, 1'b1, 1'b0);
      STEP_W'(26): w = uc_mac(2'd0, 1'b0, 2'd0, 1'b0);
      STEP_W'(27): w = uc_mac(2'd1, 1'b0, 2'd1, 1'b0);
      STEP_W'(28): w = uc_mac(2'd2, 1'b0, 2'd2, 1'b0);
      STEP_W'(29): w = uc_mac(2'd3, 1'b0, 2'd3, 1'b0);
      // deviation squared
      STEP_W'(31): w = uc_load(SRC_A_DEV, SRC_B_DEV, 1'b1, 1'b1);
      STEP_W'(32): w = uc_mac(2'd0, 1'b0, 2'd0, 1'b0);
      STEP_W'(33): w = uc_mac(2'd0, 1'b1, 2'd1, 1'b0);
      STEP_W'(34): w = uc_mac(2'd1, 1'b0, 2'd1, 1'b0);
      STEP_W'(35): w = uc_mac(2'd1, 1'b1, 2'd2, 1'b0);
      // times (n-1) scaled gives the left-hand side
      STEP_W'(37): w = uc_load(SRC_A_ACC, SRC_B_NM1S, 1'b1, 1'b0);
      STEP_W'(38): w = uc_mac(2'd0, 1'b0, 2'd0, 1'b0);
      STEP_W'(39): w = uc_mac(2'd1, 1'b0, 2'd1, 1'b0);
      STEP_W'(40): w = uc_mac(2'd2, 1'b0, 2'd2, 1'b0);
      ST_FINISH: begin
        w.commit = COMMIT_TEST;
        w.cond   = COND_OUT_BUSY;
        w.target = ST_FINISH;
        w.ret    = 1'b1;
      end
      ST_WARM: begin
        w.commit = COMMIT_WARM;
        w.cond   = COND_OUT_BUSY;
        w.target = ST_WARM;
        w.ret    = 1'b1;
      end
      default: w = uc_nop();
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* src/rolling_sigma_outlier_filter.sv */
// top level of the rolling sigma outlier filter: config registers, sequencer and datapath
// warm-up items: accepted, then dispatched to the warm-up step, which registers the result
// tested items: accepted, then the window walk in the loop step, then the 32x32 limb
//   multiplier program and the finish step; the next item waits for the return to idle
// a finished result waits in the output register while the next item is accepted
// synchronous active-low reset: window_len 5, threshold_k 829, warm-up restarts;
//   any write to window_len also restarts the warm-up
`default_nettype none

module rolling_sigma_outlier_filter #(
  parameter int MAX_WINDOW = rsof_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // sample [31:0], companion [63:32]
  input  wire logic [2*rsof_pkg::DATA_W-1:0]       in_tdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // kept_sample [31:0], kept_companion [63:32]
  output logic [2*rsof_pkg::DATA_W-1:0]            out_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rsof_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rsof_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int DW    = rsof_pkg::DATA_W;

  logic [rsof_pkg::LEN_W-1:0] len_r;
  logic [rsof_pkg::K_W-1:0]   k_r;
  logic [CNT_W-1:0]           n_eff;
  logic                       cfg_we;
  logic                       restart;
  logic                       in_accept;
  rsof_pkg::ctl_t             ctl;
  rsof_pkg::sts_t             sts;
  logic signed [DW-1:0]       out_sample;
  logic signed [DW-1:0]       out_companion;

  // configuration writes
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && (cfg_index == rsof_pkg::REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= rsof_pkg::LEN_RST;
      k_r   <= rsof_pkg::K_RST;
    end else if (cfg_we) begin
      if (cfg_index == rsof_pkg::REG_WINDOW_LEN) begin
        len_r <= cfg_data[rsof_pkg::LEN_W-1:0];
      end else if (cfg_index == rsof_pkg::REG_THRESHOLD_K) begin
        k_r <= cfg_data[rsof_pkg::K_W-1:0];
      end
    end
  end

  // window length clamped to the supported range
  always_comb begin
    priority if (32'(len_r) < 32'(rsof_pkg::MIN_WINDOW)) begin
      n_eff = CNT_W'(rsof_pkg::MIN_WINDOW);
    end else if (32'(len_r) > 32'(MAX_WINDOW)) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = CNT_W'(len_r);
    end
  end

  // input handshake
  assign in_tready = ctl.take;
  assign in_accept = in_tvalid && in_tready;

  rsof_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .sts      (sts),
    .ctl      (ctl)
  );

  rsof_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .n             (n_eff),
    .k             (k_r),
    .restart       (restart),
    .in_accept     (in_accept),
    .in_sample     (in_tdata[DW-1:0]),
    .in_companion  (in_tdata[2*DW-1:DW]),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_sample    (out_sample),
    .out_companion (out_companion),
    .sts           (sts)
  );

  assign out_tdata = {out_companion, out_sample};

endmodule

`default_nettype wire

/* src/rsof_seq.sv */
// microcode sequencer: step counter, program rom and conditional jumps
`default_nettype none

module rsof_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire rsof_pkg::sts_t sts,
  output rsof_pkg::ctl_t     ctl
);

  logic [rsof_pkg::STEP_W-1:0] step_r;
  logic [rsof_pkg::STEP_W-1:0] step_nxt;
  logic                        cond_hit;

  // current control word
  assign ctl = rsof_pkg::rsof_ucode(step_r);

  // jump condition
  always_comb begin
    unique case (ctl.cond)
      rsof_pkg::COND_NEVER:    cond_hit = 1'b0;
      rsof_pkg::COND_NO_ITEM:  cond_hit = !in_valid;
      rsof_pkg::COND_WARM:     cond_hit = sts.warm;
      rsof_pkg::COND_MORE:     cond_hit = sts.more;
      rsof_pkg::COND_OUT_BUSY: cond_hit = sts.out_busy;
      default:                 cond_hit = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    priority if (cond_hit) begin
      step_nxt = ctl.target;
    end else if (ctl.ret) begin
      step_nxt = rsof_pkg::ST_IDLE;
    end else begin
      step_nxt = step_r + rsof_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rsof_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/rsof_dp.sv */
// datapath: window memory, shared limb multiplier, accumulator and result register
`default_nettype none

module rsof_dp #(
  parameter int MAX_WINDOW = rsof_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire rsof_pkg::ctl_t                     ctl,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]    n,
  input  wire logic [rsof_pkg::K_W-1:0]           k,
  input  wire logic                               restart,
  input  wire logic                               in_accept,
  input  wire logic signed [rsof_pkg::DATA_W-1:0] in_sample,
  input  wire logic signed [rsof_pkg::DATA_W-1:0] in_companion,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic signed [rsof_pkg::DATA_W-1:0]      out_sample,
  output logic signed [rsof_pkg::DATA_W-1:0]      out_companion,
  output rsof_pkg::sts_t                          sts
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = rsof_pkg::DATA_W + CNT_W;
  localparam int DEV_W = SUM_W + 1;
  localparam int DW    = rsof_pkg::DATA_W;
  localparam int LW    = rsof_pkg::LIMB_W;
  localparam int AW    = rsof_pkg::ACC_W;
  localparam int BW    = rsof_pkg::B_W;

  logic [DW-1:0] win_mem [MAX_WINDOW];

  logic signed [DW-1:0]    x_r;
  logic signed [DW-1:0]    c_r;
  logic [IDX_W-1:0]        idx_r;
  logic [CNT_W-1:0]        fill_r;
  logic [IDX_W-1:0]        ptr_r;
  logic [IDX_W-1:0]        ptr_nxt;
  logic [DW-1:0]           rd_data_r;
  logic                    rd_v_r;
  logic [rsof_pkg::PROD_W-1:0] p_r;
  logic                    acc_en_r;
  logic [1:0]              sh_r;
  logic                    sub_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [AW-1:0]           acc_r;
  logic [AW-1:0]           acc_nxt;
  logic [rsof_pkg::ACC_LIMBS-1:0][LW-1:0] a_r;
  logic [rsof_pkg::B_LIMBS-1:0][LW-1:0]   b_r;
  logic [AW-1:0]           r_r;
  logic                    out_valid_r;
  logic signed [DW-1:0]    out_sample_r;
  logic signed [DW-1:0]    out_companion_r;

  logic                    out_busy;
  logic                    commit_go;
  logic                    keep;
  logic [IDX_W-1:0]        wr_addr;
  logic [DW-1:0]           rd_mag;
  logic [LW-1:0]           mul_a;
  logic [LW-1:0]           mul_b;
  logic [AW-1:0]           p_shift;
  logic signed [DEV_W-1:0] nx;
  logic signed [DEV_W-1:0] dev;
  logic [DEV_W-1:0]        dev_mag;
  logic [SUM_W-1:0]        sum_mag;

  // commit and keep decision
  assign out_busy  = out_valid_r && !out_ready;
  assign commit_go = (ctl.commit != rsof_pkg::COMMIT_NONE) && !out_busy;
  assign keep      = (ctl.commit == rsof_pkg::COMMIT_WARM) || !(acc_r > r_r);
  assign wr_addr   = (ctl.commit == rsof_pkg::COMMIT_WARM) ? fill_r[IDX_W-1:0] : ptr_r;

  // ring pointer wraps at the window length
  assign ptr_nxt = ((CNT_W'(ptr_r) + CNT_W'(1)) == n) ? '0 : ptr_r + IDX_W'(1);

  // status for the sequencer
  assign sts.warm     = fill_r < n;
  assign sts.more     = CNT_W'(idx_r) != (n - CNT_W'(1));
  assign sts.out_busy = out_busy;

  // window memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (commit_go) begin
      win_mem[wr_addr] <= x_r;
    end
    if (ctl.rd) begin
      rd_data_r <= win_mem[idx_r];
    end
  end

  // deviation of n*x from the sum, and magnitude of the sum
  assign nx      = DEV_W'(signed'({1'b0, n})) * DEV_W'(x_r);
  assign dev     = nx - DEV_W'(sum_r);
  assign dev_mag = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  // shared multiplier operands: squares during the walk, limbs otherwise
  assign rd_mag = rd_data_r[DW-1] ? (DW'(0) - rd_data_r) : rd_data_r;
  assign mul_a  = rd_v_r ? rd_mag : a_r[ctl.a_limb];
  assign mul_b  = rd_v_r ? rd_mag : b_r[ctl.b_limb];

  // accumulator
  assign p_shift = AW'(p_r) << (LW * int'(sh_r));

  always_comb begin
    priority if (ctl.clr_acc || ctl.init) begin
      acc_nxt = '0;
    end else if (acc_en_r) begin
      acc_nxt = sub_r ? (acc_r - p_shift) : (acc_r + p_shift);
    end else begin
      acc_nxt = acc_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      ptr_r       <= '0;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (restart) begin
        fill_r <= '0;
        ptr_r  <= '0;
      end else if (commit_go && (ctl.commit == rsof_pkg::COMMIT_WARM)) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (commit_go) begin
        ptr_r <= ptr_nxt;
      end
      if (ctl.init) begin
        idx_r <= '0;
      end else if (ctl.rd) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      rd_v_r   <= ctl.rd;
      acc_en_r <= rd_v_r || ctl.mac;
      if (commit_go && keep) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_r <= in_sample;
      c_r <= in_companion;
    end
    if (ctl.init) begin
      sum_r <= '0;
    end else if (rd_v_r) begin
      sum_r <= sum_r + SUM_W'(signed'(rd_data_r));
    end
    if (rd_v_r || ctl.mac) begin
      p_r   <= rsof_pkg::PROD_W'(mul_a) * rsof_pkg::PROD_W'(mul_b);
      sh_r  <= rd_v_r ? 2'd0 : ctl.sh;
      sub_r <= rd_v_r ? 1'b0 : ctl.sub;
    end
    acc_r <= acc_nxt;
    unique case (ctl.ld_a)
      rsof_pkg::SRC_A_NONE: a_r <= a_r;
      rsof_pkg::SRC_A_ACC:  a_r <= acc_r;
      rsof_pkg::SRC_A_SM:   a_r <= AW'(sum_mag);
      rsof_pkg::SRC_A_DEV:  a_r <= AW'(dev_mag);
      default:              a_r <= a_r;
    endcase
    unique case (ctl.ld_b)
      rsof_pkg::SRC_B_NONE: b_r <= b_r;
      rsof_pkg::SRC_B_N:    b_r <= BW'(n);
      rsof_pkg::SRC_B_K:    b_r <= BW'(k);
      rsof_pkg::SRC_B_SM:   b_r <= BW'(sum_mag);
      rsof_pkg::SRC_B_DEV:  b_r <= BW'(dev_mag);
      rsof_pkg::SRC_B_NM1S: b_r <= BW'(n - CNT_W'(1)) << rsof_pkg::SCALE_SH;
      default:              b_r <= b_r;
    endcase
    if (ctl.ld_r) begin
      r_r <= acc_r;
    end
    if (commit_go && keep) begin
      out_sample_r    <= x_r;
      out_companion_r <= c_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_companion = out_companion_r;

endmodule

`default_nettype wire

/* src/rsof_chk.sv */
// port-level checker for the rolling sigma outlier filter and its bind
`default_nettype none

module rsof_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [2*rsof_pkg::DATA_W-1:0] out_tdata
);

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // one item in work at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // a new result only comes out of an item in work, never from the idle step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

endmodule

bind rolling_sigma_outlier_filter rsof_chk u_rsof_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
